FILE: design/table_driven_char_dfa_top_assert.svh
// Assertion macros shared by the table-driven character DFA modules.
`ifndef TABLE_DRIVEN_CHAR_DFA_TOP_ASSERT_SVH
`define TABLE_DRIVEN_CHAR_DFA_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDCDFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tdcdfa assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TDCDFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tdcdfa assertion failed");

`endif

FILE: design/tdcdfa_pkg.sv
// Types, codes and the symbol matcher of the table-driven character DFA.
package tdcdfa_pkg;

  localparam logic [1:0] REQ_SYMBOL = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_FORCE  = 2'd2;

  localparam logic [8:0] CODE_END   = 9'd257;
  localparam logic [8:0] CODE_LWS   = 9'd258;
  localparam logic [8:0] CODE_ALPHA = 9'd259;
  localparam logic [8:0] CODE_DIGIT = 9'd260;
  localparam logic [8:0] CODE_HEX   = 9'd261;
  localparam logic [8:0] CODE_ANY   = 9'd262;
  localparam logic [8:0] CODE_WORD  = 9'd263;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  localparam logic [3:0] RESET_STATE = 4'd0;

  typedef enum logic [1:0] {
    OP_SYMBOL = 2'd0,
    OP_WRITE  = 2'd1,
    OP_FORCE  = 2'd2
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [8:0] symbol;
    logic [3:0] state;
    logic [2:0] entry;
    logic       enable;
    logic [8:0] code;
    logic [3:0] next;
    logic       self;
    logic [7:0] action;
  } cmd_t;

  typedef struct packed {
    logic [8:0] code;
    logic       self;
    logic [3:0] next;
    logic [7:0] action;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  function automatic logic entry_match(logic [8:0] sym, logic [8:0] code);
    logic [7:0] c;
    logic       is_byte;
    logic       alpha;
    logic       digit;
    logic       hex;
    logic       lws;
    logic       m;
    c       = sym[7:0];
    is_byte = !sym[8];
    alpha   = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    digit   = (c >= 8'h30 && c <= 8'h39);
    hex     = digit || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    lws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) ||
              (c == CH_FF) || (c == CH_VT);
    case (code)
      CODE_LWS:   m = is_byte && lws;
      CODE_ALPHA: m = is_byte && alpha;
      CODE_DIGIT: m = is_byte && digit;
      CODE_HEX:   m = is_byte && hex;
      CODE_ANY:   m = is_byte;
      CODE_WORD:  m = is_byte && (alpha || digit || c == CH_UNDER);
      default:    m = (code <= CODE_END) && (sym == code);
    endcase
    return m;
  endfunction

endpackage

FILE: design/tdcdfa_if.sv
// Valid/ready channel interfaces for request items and result items.
interface tdcdfa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [8:0] symbol;
  logic [3:0] state_index;
  logic [2:0] entry_index;
  logic       entry_enable;
  logic [8:0] entry_code;
  logic [3:0] entry_next;
  logic       entry_self;
  logic [7:0] entry_action;

  modport source (
    output valid, req_type, symbol, state_index, entry_index, entry_enable,
           entry_code, entry_next, entry_self, entry_action,
    input  ready
  );
  modport sink (
    input  valid, req_type, symbol, state_index, entry_index, entry_enable,
           entry_code, entry_next, entry_self, entry_action,
    output ready
  );
endinterface

interface tdcdfa_out_if;
  logic       valid;
  logic       ready;
  logic       matched;
  logic [3:0] prior_state;
  logic [3:0] next_state;
  logic [7:0] action_index;
  logic [8:0] symbol_echo;

  modport source (
    output valid, matched, prior_state, next_state, action_index, symbol_echo,
    input  ready
  );
  modport sink (
    input  valid, matched, prior_state, next_state, action_index, symbol_echo,
    output ready
  );
endinterface

FILE: design/tdcdfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdcdfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/tdcdfa_front.sv
// Front end: accepts request items, drops ignored ones and queues commands.
`include "table_driven_char_dfa_top_assert.svh"

module tdcdfa_front #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tdcdfa_in_if.sink         in_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output tdcdfa_pkg::cmd_t  cmd_o
);

  localparam logic [1:0] FIFO_FULL = 2'd2;

  tdcdfa_pkg::cmd_t slot_q [2];
  tdcdfa_pkg::cmd_t new_cmd;
  logic             wptr_q;
  logic             rptr_q;
  logic [1:0]       count_q;
  logic [1:0]       count_d;
  logic             keep;
  logic             push;
  logic             pop;
  logic             state_ok;
  logic             entry_ok;

  always_comb begin
    state_ok = 32'(in_i.state_index) < NUM_STATES;
    entry_ok = 32'(in_i.entry_index) < MAX_ENTRIES;

    new_cmd.op     = tdcdfa_pkg::OP_SYMBOL;
    new_cmd.symbol = in_i.symbol;
    new_cmd.state  = in_i.state_index;
    new_cmd.entry  = in_i.entry_index;
    new_cmd.enable = in_i.entry_enable;
    new_cmd.code   = in_i.entry_code;
    new_cmd.next   = in_i.entry_next;
    new_cmd.self   = in_i.entry_self;
    new_cmd.action = in_i.entry_action;

    unique case (in_i.req_type)
      tdcdfa_pkg::REQ_SYMBOL: begin
        keep = 1'b1;
      end
      tdcdfa_pkg::REQ_WRITE: begin
        new_cmd.op = tdcdfa_pkg::OP_WRITE;
        keep       = state_ok && entry_ok;
      end
      tdcdfa_pkg::REQ_FORCE: begin
        new_cmd.op = tdcdfa_pkg::OP_FORCE;
        keep       = state_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_i.ready  = (count_q != FIFO_FULL);
  assign push        = in_i.valid && in_i.ready && keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = slot_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wptr_q <= !wptr_q;
      end
      if (pop) begin
        rptr_q <= !rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= new_cmd;
    end
  end

  `TDCDFA_ASSERT_NXT(a_push_count, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + 2'd1)
  `TDCDFA_ASSERT_NXT(a_pop_count, clk_i, rst_ni, pop && !push, count_q == $past(count_q) - 2'd1)
  `TDCDFA_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, count_q != 2'd3)

endmodule

FILE: design/tdcdfa_back.sv
// Back end: executes table writes, state forces and symbol lookups.
`include "table_driven_char_dfa_top_assert.svh"

module tdcdfa_back #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_wdata_i,
  input  logic             cmd_valid_i,
  output logic             cmd_ready_o,
  input  tdcdfa_pkg::cmd_t cmd_i,
  tdcdfa_out_if.source     out_o
);

  localparam int unsigned SW = $clog2(NUM_STATES);
  localparam int unsigned EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  typedef struct packed {
    logic       matched;
    logic [3:0] prior_state;
    logic [3:0] next_state;
    logic [7:0] action_index;
    logic [8:0] symbol_echo;
  } res_t;

  state_e                 state_q;
  state_e                 state_d;
  logic [3:0]             cur_state_q;
  logic [3:0]             cur_state_d;
  logic [3:0]             init_state_q;
  logic                   boot_q;
  logic [8:0]             sym_q;
  logic [MAX_ENTRIES-1:0] en_q [NUM_STATES];
  logic [MAX_ENTRIES-1:0] row_en;
  tdcdfa_pkg::entry_t     rd_data [MAX_ENTRIES];
  tdcdfa_pkg::entry_t     wr_entry;
  tdcdfa_pkg::entry_t     pick;
  logic                   hit;
  logic                   out_valid_q;
  logic                   out_valid_d;
  res_t                   res_q;
  res_t                   res_d;
  logic                   pop;
  logic                   wr_en;
  logic                   sym_re;
  logic                   load_out;
  logic [SW-1:0]          rd_row;
  logic [SW-1:0]          wr_row;
  logic [EW-1:0]          wr_col;

  assign cmd_ready_o = (state_q == ST_IDLE) && !boot_q;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign wr_en       = pop && (cmd_i.op == tdcdfa_pkg::OP_WRITE);
  assign sym_re      = pop && (cmd_i.op == tdcdfa_pkg::OP_SYMBOL);
  assign rd_row      = SW'(cur_state_q);
  assign wr_row      = SW'(cmd_i.state);
  assign wr_col      = EW'(cmd_i.entry);
  assign wr_entry    = '{code: cmd_i.code, self: cmd_i.self, next: cmd_i.next,
                         action: cmd_i.action};
  assign load_out    = (state_q == ST_LOOK) && (!out_valid_q || out_o.ready);

  for (genvar b = 0; b < MAX_ENTRIES; b++) begin : g_bank
    logic [tdcdfa_pkg::ENTRY_W-1:0] rdata;

    tdcdfa_ram #(
      .WIDTH(tdcdfa_pkg::ENTRY_W),
      .DEPTH(NUM_STATES)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (wr_en && (int'(cmd_i.entry) == b)),
      .waddr_i(wr_row),
      .wdata_i(wr_entry),
      .re_i   (sym_re),
      .raddr_i(rd_row),
      .rdata_o(rdata)
    );

    assign rd_data[b] = tdcdfa_pkg::entry_t'(rdata);
  end

  // The first enabled entry of the row that matches the symbol wins.
  always_comb begin
    row_en = en_q[rd_row];
    hit    = 1'b0;
    pick   = rd_data[0];
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (!hit && row_en[i] && tdcdfa_pkg::entry_match(sym_q, rd_data[i].code)) begin
        hit  = 1'b1;
        pick = rd_data[i];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    cur_state_d = cur_state_q;
    out_valid_d = out_valid_q && !out_o.ready;

    res_d.matched      = hit;
    res_d.prior_state  = cur_state_q;
    res_d.next_state   = (hit && !pick.self) ? pick.next : cur_state_q;
    res_d.action_index = hit ? pick.action : 8'd0;
    res_d.symbol_echo  = sym_q;

    // The current state takes the initial-state register in the boot cycle that follows reset.
    if (boot_q) begin
      cur_state_d = init_state_q;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (sym_re) begin
          state_d = ST_LOOK;
        end else if (pop && (cmd_i.op == tdcdfa_pkg::OP_FORCE)) begin
          cur_state_d = cmd_i.state;
        end
      end
      ST_LOOK: begin
        if (load_out) begin
          cur_state_d = res_d.next_state;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_state_q  <= tdcdfa_pkg::RESET_STATE;
      init_state_q <= tdcdfa_pkg::RESET_STATE;
      boot_q       <= 1'b1;
      out_valid_q  <= 1'b0;
      for (int r = 0; r < NUM_STATES; r++) begin
        en_q[r] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cur_state_q <= cur_state_d;
      boot_q      <= 1'b0;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        init_state_q <= cfg_wdata_i;
      end
      if (wr_en) begin
        en_q[wr_row][wr_col] <= cmd_i.enable;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (sym_re) begin
      sym_q <= cmd_i.symbol;
    end
    if (load_out) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.matched      = res_q.matched;
  assign out_o.prior_state  = res_q.prior_state;
  assign out_o.next_state   = res_q.next_state;
  assign out_o.action_index = res_q.action_index;
  assign out_o.symbol_echo  = res_q.symbol_echo;

  `TDCDFA_ASSERT_NXT(a_look_done, clk_i, rst_ni, state_q == ST_LOOK && !out_valid_q, state_q == ST_IDLE && out_valid_q)
  `TDCDFA_ASSERT_NXT(a_miss_keeps, clk_i, rst_ni, load_out && !hit, cur_state_q == $past(cur_state_q))
  `TDCDFA_ASSERT_NXT(a_prior_state, clk_i, rst_ni, load_out, out_o.prior_state == $past(cur_state_q))

endmodule

FILE: design/table_driven_char_dfa_top.sv
// Top level of the table-driven character DFA with character classes.
//
// Requests enter on in_i and results leave on out_o; both are valid/ready
// channels, and a transfer happens on a clock edge with valid and ready high.
// A symbol request looks up the enabled entries of the current state and
// returns exactly one result; write and force requests and ignored requests
// return nothing. A two-entry queue separates the front end from the back end.
// For a symbol the back end first reads the whole row of entries from the
// per-position banks, then picks the first match and updates the state.
// Writes and forces complete when the back end takes them from the queue.
// Reset clears all entry enables at once and sets the current state to zero;
// cfg_we_i writes the initial-state register. While out_o is stalled the
// result holds, the back end stops after its lookup and the queue keeps
// taking requests until it is full.
module table_driven_char_dfa_top #(
  parameter int unsigned NUM_STATES  = 16,
  parameter int unsigned MAX_ENTRIES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [3:0]   cfg_wdata_i,
  tdcdfa_in_if.sink    in_i,
  tdcdfa_out_if.source out_o
);

  logic             cmd_valid;
  logic             cmd_ready;
  tdcdfa_pkg::cmd_t cmd;

  tdcdfa_front #(
    .NUM_STATES (NUM_STATES),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  tdcdfa_back #(
    .NUM_STATES (NUM_STATES),
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_valid_i(cmd_valid),
    .cmd_ready_o(cmd_ready),
    .cmd_i      (cmd),
    .out_o      (out_o)
  );

endmodule
